FILE: hw/rtl/pvd_pkg.sv
// pvd_pkg: beat and state types for the prefix varint decoder.
// No dependencies; imported by pvd_step and prefix_varint_decoder.
package pvd_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 4;

  // Low nibble selector codes of a 1111xxxx leading byte (bits 3:2)
  localparam logic [1:0] SUB_FIXED32 = 2'b00;
  localparam logic [1:0] SUB_FIXED64 = 2'b01;
  localparam logic [1:0] SUB_INVERT  = 2'b10;
  localparam logic [1:0] SUB_SMALL   = 2'b11;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_req;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] byte_count;
  } result_t;

  typedef struct packed {
    logic              invert_pending;
    logic [3:0]        bytes_remaining;
    logic [ValueW-1:0] accumulator;
    logic [CountW-1:0] length_so_far;
  } dec_state_t;

endpackage

FILE: hw/rtl/pvd_step.sv
// pvd_step: combinational next-state and result logic for one byte.
// Depends on pvd_pkg.
module pvd_step
  import pvd_pkg::*;
(
  input  dec_state_t st,
  input  item_t      item,
  output dec_state_t st_next,
  output logic       emit,
  output result_t    res
);

  dec_state_t        base;
  logic [7:0]        b;
  logic [CountW-1:0] len;
  logic [ValueW-1:0] raw;
  logic [3:0]        rem_dec;

  always_comb begin
    b    = item.code_byte;
    base = item.start_req ? '0 : st;
    // saturating length bump
    len  = (base.length_so_far == {CountW{1'b1}}) ? base.length_so_far
                                                  : base.length_so_far + CountW'(1);
    rem_dec = base.bytes_remaining - 4'd1;
    raw     = '0;
    emit    = 1'b0;
    st_next = base;
    st_next.length_so_far = len;

    if (base.bytes_remaining != 4'd0) begin
      st_next.accumulator     = {base.accumulator[ValueW-9:0], b};
      st_next.bytes_remaining = rem_dec;
      if (rem_dec == 4'd0) begin
        emit = 1'b1;
        raw  = {base.accumulator[ValueW-9:0], b};
      end
    end else if (!b[7]) begin
      emit = 1'b1;
      raw  = {{(ValueW-7){1'b0}}, b[6:0]};
    end else if (b[7:6] == 2'b10) begin
      st_next.accumulator     = {{(ValueW-6){1'b0}}, b[5:0]};
      st_next.bytes_remaining = 4'd1;
    end else if (b[7:5] == 3'b110) begin
      st_next.accumulator     = {{(ValueW-5){1'b0}}, b[4:0]};
      st_next.bytes_remaining = 4'd2;
    end else if (b[7:4] == 4'b1110) begin
      st_next.accumulator     = {{(ValueW-4){1'b0}}, b[3:0]};
      st_next.bytes_remaining = 4'd3;
    end else begin
      unique case (b[3:2])
        SUB_FIXED32: begin
          st_next.accumulator     = '0;
          st_next.bytes_remaining = 4'd4;
        end
        SUB_FIXED64: begin
          st_next.accumulator     = '0;
          st_next.bytes_remaining = 4'd8;
        end
        SUB_INVERT: st_next.invert_pending = ~base.invert_pending;
        SUB_SMALL: begin
          emit = 1'b1;
          raw  = ~{{(ValueW-2){1'b0}}, b[1:0]};
        end
        default: ;
      endcase
    end

    res.value      = base.invert_pending ? ~raw : raw;
    res.byte_count = len;
    if (emit) begin
      st_next = '0;
    end
  end

endmodule

FILE: hw/rtl/prefix_varint_decoder.sv
// prefix_varint_decoder: top level, byte-stream prefix varint decoder.
// Latency: a result appears in the cycle after its completing byte is accepted.
// Throughput: one byte per cycle while no held result waits on result_ready; each
// byte decodes in a single pass of pvd_step between the state and result registers.
// Reset: synchronous active-high rst clears the decode state and the result
// valid; input ready is held low while rst is high.
module prefix_varint_decoder
  import pvd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  dec_state_t st;
  dec_state_t st_next;
  logic       emit;
  result_t    res;
  logic       take;

  // Result register doubles as the skid: a new byte is taken whenever the
  // held result leaves in the same cycle or none is held.
  assign item_ready = !rst && (!result_valid || result_ready);
  assign take       = item_valid && item_ready;

  pvd_step u_step (
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .emit    (emit),
    .res     (res)
  );

  // decode state: prefix flag, remaining payload bytes, accumulator, length
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result <= res;
    end
  end

  // a delivered varint is always at least one byte long
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.byte_count != '0)
    else $error("result beat with zero byte_count");

  // reset leaves the decoder idle with no result held
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (st.bytes_remaining == 4'd0 && !result_valid))
    else $error("decoder not idle after reset");

  // a forced start on a one-byte form completes at once with length one
  a_start_short: assert property (@(posedge clk) disable iff (rst)
    (take && item.start_req && !item.code_byte[7]) |=>
      (result_valid && result.byte_count == 4'd1))
    else $error("one-byte varint after start not delivered");

  // mid-varint, a taken byte with more than one payload byte left never emits and steps the remaining count down by one
  a_busy_no_emit: assert property (@(posedge clk) disable iff (rst)
    (take && !item.start_req && st.bytes_remaining > 4'd1) |=>
      (!result_valid && st.bytes_remaining == $past(st.bytes_remaining) - 4'd1))
    else $error("payload byte count did not step down");

endmodule
